// ===== hw/rtl/ptt_pkg.sv =====
// Package for the periodic timer table: sizes, codes and the slot record.
package ptt_pkg;

    localparam int SLOTS       = 8;
    localparam int TICK_BITS   = 16;
    localparam int ID_BITS     = 8;
    localparam int MAX_RESULTS = 8;

    localparam int REQ_W   = 2;
    localparam int IN_ID_W = 8;
    localparam int PER_W   = 16;
    localparam int RUN_W   = 8;
    localparam int STAT_W  = 3;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

    typedef logic [ID_BITS-1:0]   t_id;
    typedef logic [TICK_BITS-1:0] t_tick;
    typedef logic [RUN_W-1:0]     t_runs;
    typedef logic [SLOT_W-1:0]    t_slot_idx;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK = 2'd0,
        REQ_ADD  = 2'd1,
        REQ_DEL  = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_FIRED    = 3'd0,
        ST_ADDED    = 3'd1,
        ST_DELETED  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        t_id   id;
        t_tick period;
        t_tick remaining;
        t_runs runs;
    } t_slot;

    typedef struct packed {
        logic      we;
        t_slot_idx waddr;
        t_slot     wdata;
        t_slot_idx raddr;
    } t_ram_ctl;

endpackage

// ===== hw/rtl/ptt_slot_ram.sv =====
// Slot record memory: one write port, one read port with registered data.
module ptt_slot_ram (
    input  logic            i_clk,
    input  ptt_pkg::t_ram_ctl i_ctl,
    output ptt_pkg::t_slot  o_rdata
);
    import ptt_pkg::*;

    t_slot r_mem [SLOTS];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_rdata <= r_mem[i_ctl.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/periodic_timer_table_unit.sv =====
// Periodic timer table: slot records in memory, walked one slot per cycle.
// Add: result on the ports the cycle after accept; busy stays low, so the next item need not wait.
// Delete: walks slots to the first match and gives one final result, deleted or not found.
// Tick: walks all slots, one per cycle, and stays busy until the flush state has sent
//   the last result. One walk at a time; results cannot stall.
// Reset clears the valid bits and control; no memory clearing pass.
module periodic_timer_table_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ptt_pkg::REQ_W-1:0]   i_req_type,
    input  logic [ptt_pkg::IN_ID_W-1:0] i_task_id,
    input  logic [ptt_pkg::PER_W-1:0]   i_period,
    input  logic [ptt_pkg::RUN_W-1:0]   i_run_count,
    output logic                        o_valid,
    output logic [ptt_pkg::STAT_W-1:0]  o_status,
    output logic [ptt_pkg::IN_ID_W-1:0] o_fired_id,
    output logic                        o_last
);
    import ptt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    localparam t_slot_idx LAST_IDX = SLOT_W'(SLOTS - 1);

    t_state     r_state, n_state;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic       r_is_tick, n_is_tick;
    t_id        r_id, n_id;
    logic       r_issue, n_issue;
    t_slot_idx  r_idx, n_idx;
    logic       r_proc_en, n_proc_en;
    t_slot_idx  r_proc_idx, n_proc_idx;
    logic       r_pend, n_pend;
    t_id        r_pend_id, n_pend_id;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    t_status    r_out_status, n_out_status;
    t_id        r_out_id, n_out_id;
    logic       r_out_last, n_out_last;

    t_ram_ctl   ram_ctl;
    t_slot      rdata;
    t_slot      wr_rec;
    t_tick      in_per;
    t_id        in_id;
    t_tick      rem_dec;
    logic       free_any;
    t_slot_idx  free_idx;
    logic       accept;

    ptt_slot_ram u_ram (
        .i_clk  (i_clk),
        .i_ctl  (ram_ctl),
        .o_rdata(rdata)
    );

    assign accept = start && !busy;
    assign in_id  = ID_BITS'(i_task_id);
    assign rem_dec = rdata.remaining - 1'b1;

    always_comb begin
        in_per = TICK_BITS'(i_period);
        if (in_per == '0) begin
            in_per = t_tick'(1);
        end
    end

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_is_tick    = r_is_tick;
        n_id         = r_id;
        n_issue      = r_issue;
        n_idx        = r_idx;
        n_proc_en    = 1'b0;
        n_proc_idx   = r_proc_idx;
        n_pend       = r_pend;
        n_pend_id    = r_pend_id;
        n_cnt        = r_cnt;
        n_out_valid  = 1'b0;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_last   = r_out_last;
        ram_ctl.we    = 1'b0;
        ram_ctl.waddr = r_proc_idx;
        ram_ctl.wdata = rdata;
        ram_ctl.raddr = r_idx;
        wr_rec        = rdata;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_id      = in_id;
                    n_is_tick = (i_req_type == REQ_TICK);
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    n_cnt     = '0;
                    case (i_req_type)
                        REQ_ADD: begin
                            n_out_valid = 1'b1;
                            n_out_id    = in_id;
                            n_out_last  = 1'b1;
                            if (free_any) begin
                                n_out_status  = ST_ADDED;
                                n_valid[free_idx] = 1'b1;
                                ram_ctl.we    = 1'b1;
                                ram_ctl.waddr = free_idx;
                                ram_ctl.wdata = '{id: in_id, period: in_per,
                                                  remaining: in_per, runs: i_run_count};
                            end else begin
                                n_out_status = ST_FULL;
                            end
                        end
                        REQ_TICK, REQ_DEL: begin
                            n_state = S_WALK;
                            n_issue = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (r_issue) begin
                    n_proc_en  = 1'b1;
                    n_proc_idx = r_idx;
                    n_idx      = r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end
                end
                if (r_proc_en) begin
                    if (r_is_tick) begin
                        if (r_valid[r_proc_idx]) begin
                            if (rem_dec != '0) begin
                                wr_rec.remaining = rem_dec;
                                ram_ctl.we    = 1'b1;
                                ram_ctl.wdata = wr_rec;
                            end else begin
                                if (r_cnt < CNT_W'(MAX_RESULTS)) begin
                                    if (r_pend) begin
                                        n_out_valid  = 1'b1;
                                        n_out_status = ST_FIRED;
                                        n_out_id     = r_pend_id;
                                        n_out_last   = 1'b0;
                                    end
                                    n_pend    = 1'b1;
                                    n_pend_id = rdata.id;
                                    n_cnt     = r_cnt + 1'b1;
                                end
                                if (rdata.runs == t_runs'(1)) begin
                                    n_valid[r_proc_idx] = 1'b0;
                                end else begin
                                    wr_rec.remaining = rdata.period;
                                    if (rdata.runs != '0) begin
                                        wr_rec.runs = rdata.runs - 1'b1;
                                    end
                                    ram_ctl.we    = 1'b1;
                                    ram_ctl.wdata = wr_rec;
                                end
                            end
                        end
                        if (r_proc_idx == LAST_IDX) begin
                            n_state = S_FLUSH;
                        end
                    end else begin
                        if (r_valid[r_proc_idx] && rdata.id == r_id) begin
                            n_valid[r_proc_idx] = 1'b0;
                            n_out_valid  = 1'b1;
                            n_out_status = ST_DELETED;
                            n_out_id     = r_id;
                            n_out_last   = 1'b1;
                            n_state      = S_IDLE;
                            n_issue      = 1'b0;
                            n_proc_en    = 1'b0;
                        end else if (r_proc_idx == LAST_IDX) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_NOTFOUND;
                            n_out_id     = r_id;
                            n_out_last   = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (r_pend) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_FIRED;
                    n_out_id     = r_pend_id;
                    n_out_last   = 1'b1;
                end
                n_pend  = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_issue     <= 1'b0;
            r_proc_en   <= 1'b0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_issue     <= n_issue;
            r_proc_en   <= n_proc_en;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_tick    <= n_is_tick;
        r_id         <= n_id;
        r_idx        <= n_idx;
        r_proc_idx   <= n_proc_idx;
        r_pend_id    <= n_pend_id;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_last   <= n_out_last;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_fired_id = IN_ID_W'(r_out_id);
    assign o_last     = r_out_last;

endmodule

// ===== hw/rtl/ptt_checker.sv =====
// Port-level checks for the periodic timer table, bound to the top level.
module ptt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [ptt_pkg::REQ_W-1:0]   i_req_type,
    input logic [ptt_pkg::IN_ID_W-1:0] i_task_id,
    input logic                        o_valid,
    input logic [ptt_pkg::STAT_W-1:0]  o_status,
    input logic [ptt_pkg::IN_ID_W-1:0] o_fired_id,
    input logic                        o_last
);
    import ptt_pkg::*;

    a_add_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type == REQ_ADD |=>
            o_valid && o_last && (o_status == ST_ADDED || o_status == ST_FULL))
        else $error("add item did not give one final result");

    a_add_echo_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type == REQ_ADD |=> o_fired_id == $past(i_task_id))
        else $error("add result id differs from the item id");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_FIRED |-> o_last)
        else $error("non-fire result without last");

    a_more_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("result stream open while idle");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !start |=> !o_valid)
        else $error("result without an item");

endmodule

bind periodic_timer_table_unit ptt_checker u_ptt_checker (.*);

// ===== test/periodic_timer_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the periodic timer table: slot model, expected-report queue and compare.
module periodic_timer_table_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [ptt_pkg::REQ_W-1:0]   i_req_type,
    input  logic [ptt_pkg::IN_ID_W-1:0] i_task_id,
    input  logic [ptt_pkg::PER_W-1:0]   i_period,
    input  logic [ptt_pkg::RUN_W-1:0]   i_run_count,
    input  logic                        i_valid,
    input  logic [ptt_pkg::STAT_W-1:0]  i_status,
    input  logic [ptt_pkg::IN_ID_W-1:0] i_fired_id,
    input  logic                        i_last,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    typedef struct packed {
        logic [ptt_pkg::STAT_W-1:0]  status;
        logic [ptt_pkg::IN_ID_W-1:0] id;
        logic                        last;
    } t_report;

    t_report pending_reports[$];

    logic           slot_live   [ptt_pkg::SLOTS];
    ptt_pkg::t_id   slot_tag    [ptt_pkg::SLOTS];
    ptt_pkg::t_tick slot_reload [ptt_pkg::SLOTS];
    ptt_pkg::t_tick slot_count  [ptt_pkg::SLOTS];
    ptt_pkg::t_runs slot_runs   [ptt_pkg::SLOTS];

    int fail_count;
    int checked;

    task automatic queue_report(input logic [ptt_pkg::STAT_W-1:0] status,
                                input ptt_pkg::t_id id, input logic last);
        t_report rep;
        rep.status = status;
        rep.id     = id;
        rep.last   = last;
        pending_reports.push_back(rep);
    endtask

    task automatic apply_request(input logic [ptt_pkg::REQ_W-1:0] req,
                                 input logic [ptt_pkg::IN_ID_W-1:0] id_in,
                                 input logic [ptt_pkg::PER_W-1:0] per_in,
                                 input logic [ptt_pkg::RUN_W-1:0] runs_in);
        ptt_pkg::t_id   id;
        ptt_pkg::t_tick per;
        ptt_pkg::t_id   fired [ptt_pkg::MAX_RESULTS];
        int             n;
        int             i;
        bit             placed;
        id     = id_in[ptt_pkg::ID_BITS-1:0];
        per    = per_in[ptt_pkg::TICK_BITS-1:0];
        n      = 0;
        placed = 1'b0;
        case (req)
            ptt_pkg::REQ_TICK: begin
                for (i = 0; i < ptt_pkg::SLOTS; i++) begin
                    if (slot_live[i]) begin
                        slot_count[i] = slot_count[i] - 1'b1;
                        if (slot_count[i] == '0) begin
                            if (n < ptt_pkg::MAX_RESULTS) begin
                                fired[n] = slot_tag[i];
                                n++;
                            end
                            if (slot_runs[i] != '0 && slot_runs[i] - 1'b1 == '0) begin
                                slot_runs[i] = '0;
                                slot_live[i] = 1'b0;
                            end else begin
                                if (slot_runs[i] != '0)
                                    slot_runs[i] = slot_runs[i] - 1'b1;
                                slot_count[i] = slot_reload[i];
                            end
                        end
                    end
                end
                for (i = 0; i < n; i++)
                    queue_report(ptt_pkg::ST_FIRED, fired[i], i == n - 1);
            end
            ptt_pkg::REQ_ADD: begin
                if (per == '0)
                    per = ptt_pkg::t_tick'(1);
                for (i = 0; i < ptt_pkg::SLOTS; i++) begin
                    if (!placed && !slot_live[i]) begin
                        placed         = 1'b1;
                        slot_live[i]   = 1'b1;
                        slot_tag[i]    = id;
                        slot_reload[i] = per;
                        slot_count[i]  = per;
                        slot_runs[i]   = runs_in;
                    end
                end
                queue_report(placed ? ptt_pkg::ST_ADDED : ptt_pkg::ST_FULL, id, 1'b1);
            end
            ptt_pkg::REQ_DEL: begin
                for (i = 0; i < ptt_pkg::SLOTS; i++) begin
                    if (!placed && slot_live[i] && slot_tag[i] == id) begin
                        placed       = 1'b1;
                        slot_live[i] = 1'b0;
                    end
                end
                queue_report(placed ? ptt_pkg::ST_DELETED : ptt_pkg::ST_NOTFOUND, id, 1'b1);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_report want;
        if (!i_rst_n) begin
            for (int i = 0; i < ptt_pkg::SLOTS; i++)
                slot_live[i] = 1'b0;
            pending_reports.delete();
            fail_count = 0;
            checked    = 0;
        end else begin
            if (i_valid === 1'b1) begin
                checked++;
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result: status %0d id %0h last %0b",
                             $time, i_status, i_fired_id, i_last);
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (i_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, i_status);
                        fail_count++;
                    end
                    if (i_fired_id !== want.id) begin
                        $display("%0t: id mismatch: expected %0h, got %0h",
                                 $time, want.id, i_fired_id);
                        fail_count++;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.last, i_last);
                        fail_count++;
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0)
                apply_request(i_req_type, i_task_id, i_period, i_run_count);
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_reports.size();
        o_checked    <= checked;
    end

endmodule

// ===== test/periodic_timer_table_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the periodic timer table: clock, reset, request stimulus and verdict.
module periodic_timer_table_unit_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 300;
    localparam int TAIL_CYCLES  = ptt_pkg::SLOTS + 8;
    localparam logic [ptt_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [ptt_pkg::REQ_W-1:0]   i_req_type;
    logic [ptt_pkg::IN_ID_W-1:0] i_task_id;
    logic [ptt_pkg::PER_W-1:0]   i_period;
    logic [ptt_pkg::RUN_W-1:0]   i_run_count;
    logic                        o_valid;
    logic [ptt_pkg::STAT_W-1:0]  o_status;
    logic [ptt_pkg::IN_ID_W-1:0] o_fired_id;
    logic                        o_last;

    int fail_count;
    int pending;
    int checked;
    int cycle_count;
    int n_ticks, n_adds, n_deletes, n_ignored;
    int sent;
    int pick;
    bit gaps_on;
    bit calm_stretch;
    logic [ptt_pkg::IN_ID_W-1:0] pick_id;
    logic [ptt_pkg::PER_W-1:0]   pick_per;
    logic [ptt_pkg::RUN_W-1:0]   pick_runs;
    logic [ptt_pkg::IN_ID_W-1:0] added_ids[$];

    periodic_timer_table_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_task_id   (i_task_id),
        .i_period    (i_period),
        .i_run_count (i_run_count),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_fired_id  (o_fired_id),
        .o_last      (o_last)
    );

    periodic_timer_table_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req_type   (i_req_type),
        .i_task_id    (i_task_id),
        .i_period     (i_period),
        .i_run_count  (i_run_count),
        .i_valid      (o_valid),
        .i_status     (o_status),
        .i_fired_id   (o_fired_id),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_request(input logic [ptt_pkg::REQ_W-1:0] req,
                                input logic [ptt_pkg::IN_ID_W-1:0] id,
                                input logic [ptt_pkg::PER_W-1:0] per,
                                input logic [ptt_pkg::RUN_W-1:0] runs);
        logic taken;
        taken       = 1'b0;
        i_req_type  = req;
        i_task_id   = id;
        i_period    = per;
        i_run_count = runs;
        start       = 1'b1;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
            @(negedge i_clk);
        end
        case (req)
            ptt_pkg::REQ_TICK: n_ticks++;
            ptt_pkg::REQ_ADD:  n_adds++;
            ptt_pkg::REQ_DEL:  n_deletes++;
            default:           n_ignored++;
        endcase
    endtask

    task automatic idle_cycles(input int n);
        start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req_type  = ptt_pkg::REQ_TICK;
        i_task_id   = '0;
        i_period    = '0;
        i_run_count = '0;
        n_ticks     = 0;
        n_adds      = 0;
        n_deletes   = 0;
        n_ignored   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: quiet tick, unknown request, period zero, single run
        send_request(ptt_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00);
        send_request(REQ_UNKNOWN, 8'hFF, 16'hFFFF, 8'hFF);
        send_request(ptt_pkg::REQ_ADD, 8'hFF, 16'h0000, 8'h01);
        send_request(ptt_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00);
        send_request(ptt_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00);
        // fill the table, duplicates included, then overflow it
        send_request(ptt_pkg::REQ_ADD, 8'h00, 16'hFFFF, 8'h00);
        send_request(ptt_pkg::REQ_ADD, 8'hA5, 16'h0001, 8'h00);
        send_request(ptt_pkg::REQ_ADD, 8'h5A, 16'h0002, 8'hFF);
        send_request(ptt_pkg::REQ_ADD, 8'hA5, 16'h0003, 8'h02);
        send_request(ptt_pkg::REQ_ADD, 8'h11, 16'h0001, 8'h03);
        send_request(ptt_pkg::REQ_ADD, 8'h22, 16'h0001, 8'h03);
        send_request(ptt_pkg::REQ_ADD, 8'h33, 16'h0001, 8'h03);
        send_request(ptt_pkg::REQ_ADD, 8'h44, 16'h0001, 8'h03);
        send_request(ptt_pkg::REQ_ADD, 8'h77, 16'h0001, 8'h01);
        send_request(ptt_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00);
        send_request(ptt_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00);
        // delete lowest duplicate, then a missing id
        send_request(ptt_pkg::REQ_DEL, 8'hA5, 16'h0000, 8'h00);
        send_request(ptt_pkg::REQ_DEL, 8'h99, 16'h0000, 8'h00);
        send_request(ptt_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00);
        send_request(ptt_pkg::REQ_DEL, 8'hA5, 16'h0000, 8'h00);
        send_request(ptt_pkg::REQ_DEL, 8'hA5, 16'h0000, 8'h00);
        send_request(ptt_pkg::REQ_ADD, 8'h3C, 16'h8000, 8'h80);
        send_request(ptt_pkg::REQ_TICK, 8'h00, 16'h0000, 8'h00);
        send_request(ptt_pkg::REQ_DEL, 8'h00, 16'h0000, 8'h00);
        wait_drained();

        sent         = 0;
        calm_stretch = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 25 == 0)
                calm_stretch = ($urandom_range(0, 3) == 0);
            gaps_on = (sent < RANDOM_ITEMS - 60) && !calm_stretch;
            if (sent == RANDOM_ITEMS / 2)
                wait_drained();
            pick_per  = ptt_pkg::t_tick'(($urandom_range(0, 4) != 0)
                                         ? $urandom_range(0, 5)
                                         : $urandom_range(0, 65535));
            pick_runs = ptt_pkg::t_runs'(($urandom_range(0, 9) < 7)
                                         ? $urandom_range(0, 4)
                                         : $urandom_range(0, 255));
            pick_id   = ptt_pkg::t_id'($urandom_range(0, 255));
            pick      = $urandom_range(0, 99);
            if (pick < 50) begin
                send_request(ptt_pkg::REQ_TICK, pick_id, pick_per, pick_runs);
                sent++;
            end else if (pick < 75) begin
                send_request(ptt_pkg::REQ_ADD, pick_id, pick_per, pick_runs);
                added_ids.push_back(pick_id);
                if (added_ids.size() > 32)
                    void'(added_ids.pop_front());
                sent++;
            end else if (pick < 95) begin
                if (added_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
                    pick    = $urandom_range(0, added_ids.size() - 1);
                    pick_id = added_ids[pick];
                    added_ids.delete(pick);
                end
                send_request(ptt_pkg::REQ_DEL, pick_id, pick_per, pick_runs);
                sent++;
            end else begin
                send_request(REQ_UNKNOWN, pick_id, pick_per, pick_runs);
            end
            if (gaps_on && $urandom_range(0, 2) == 0)
                idle_cycles($urandom_range(1, 18));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        $display("Sent %0d ticks, %0d adds, %0d deletes and %0d unknown requests.",
                 n_ticks, n_adds, n_deletes, n_ignored);
        $display("Compared %0d results against the slot model, fills and overflows included.",
                 checked);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
